// ----- hdl/pve_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pve_pkg: shared constants for the period velocity estimator
// Field widths, register indexes and reset values of the config registers.
// ----------------------------------------------------------------------------
package pve_pkg;

  localparam int POS_W   = 16;  // angle sample width
  localparam int TICK_W  = 16;  // timeout register width
  localparam int CNT_W   = 17;  // elapsed tick count, holds max_ticks + 1
  localparam int COEF_W  = 17;  // Q16 filter weight
  localparam int VEL_W   = 32;  // Q16.16 velocity
  localparam int FRAC_W  = 16;  // fraction bits of the Q16 formats
  localparam int IN_W    = 16;  // s_tdata width
  localparam int OUT_W   = 64;  // m_tdata width
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_TICKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 1'd1;

  localparam logic [TICK_W-1:0] MAX_TICKS_RST    = 16'd2000;
  localparam logic [COEF_W-1:0] FILTER_COEFF_RST = 17'd1993;
  localparam logic [COEF_W-1:0] COEF_ONE         = 17'd65536;

  localparam logic [VEL_W-1:0] VEL_MAX = 32'h7fff_ffff;
  localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

endpackage

// ----- hdl/period_velocity_estimator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_velocity_estimator_unit: elapsed-time velocity with low-pass filter
// Per tick: count ticks since the last position change, on a change divide the
// wrapped Q16.16 step by the count, time out to zero, then low-pass the result.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     s_tdata[15:0]  position
//  m_*       out  m_tvalid / m_tready     m_tdata[63:0]  velocity, filtered_velocity
//  cfg_*     in   cfg_we (no wait)        cfg_index, cfg_data
//
//  A tick with a position change runs the restoring divider (one quotient
//  bit per cycle), then one multiply, one filter add and one writeback; a
//  tick without a change skips the divider. s_tready is high only in IDLE,
//  so a new request is taken only after the last one has left writeback.
//  The result register lets the next request in while the last result waits;
//  writeback stalls until m_tready frees it. rst is synchronous and clears
//  state, config registers return to their reset values.
// ----------------------------------------------------------------------------
module period_velocity_estimator_unit (
  input  logic                             clk,
  input  logic                             rst,
  // slave request
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pve_pkg::IN_W-1:0]         s_tdata,    // [15:0] position
  // master result
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pve_pkg::OUT_W-1:0]        m_tdata,    // [31:0] velocity,
                                                       // [63:32] filtered_velocity
  // config writes
  input  logic                             cfg_we,
  input  logic [pve_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pve_pkg::CFG_DAT_W-1:0]    cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;  // shift-subtract divider
  localparam logic [2:0] ST_MUL  = 3'd2;  // (raw - smoothed) * coeff
  localparam logic [2:0] ST_FILT = 3'd3;  // round, add, saturate
  localparam logic [2:0] ST_WB   = 3'd4;  // hand result to output register

  logic [2:0] state;

  // config
  logic [pve_pkg::TICK_W-1:0] max_ticks;
  logic [pve_pkg::COEF_W-1:0] filter_coeff;

  // estimator state
  logic [pve_pkg::POS_W-1:0]        last_position;
  logic [pve_pkg::CNT_W-1:0]        elapsed_ticks;
  logic signed [pve_pkg::VEL_W-1:0] raw_velocity;
  logic signed [pve_pkg::VEL_W-1:0] smoothed_velocity;

  // divider
  logic [pve_pkg::VEL_W-1:0] dvd;      // dividend in, quotient out
  logic [pve_pkg::CNT_W-1:0] divisor;
  logic [pve_pkg::CNT_W-1:0] rem;
  logic [4:0]                div_cnt;
  logic                      quo_neg;
  logic [pve_pkg::POS_W-1:0] pos_hold;

  // filter
  logic signed [50:0] prod;

  // request decode
  logic [pve_pkg::POS_W-1:0] pos_in;
  logic [pve_pkg::POS_W-1:0] diff;
  logic [pve_pkg::VEL_W-1:0] num;
  logic [pve_pkg::VEL_W-1:0] num_mag;
  logic [pve_pkg::CNT_W-1:0] ticks_inc;
  logic                      accept;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pos_in    = s_tdata[pve_pkg::POS_W-1:0];
  assign diff      = pos_in - last_position;  // wraps naturally
  assign num       = {diff, {pve_pkg::FRAC_W{1'b0}}};
  assign num_mag   = diff[pve_pkg::POS_W-1] ? (~num + 32'd1) : num;
  assign ticks_inc = elapsed_ticks + 17'd1;

  // one divider step
  logic [pve_pkg::CNT_W:0] rem_sh;
  logic                    rem_ge;
  assign rem_sh = {rem, dvd[pve_pkg::VEL_W-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  // filter math: smoothed + floor((d*c + 2^15) / 2^16), with d = raw - smoothed
  logic [pve_pkg::COEF_W-1:0] coeff_clamped;
  logic signed [32:0]         vel_diff;
  logic signed [50:0]         prod_rnd;
  logic signed [35:0]         filt_sum;
  logic signed [pve_pkg::VEL_W-1:0] filt_sat;

  assign coeff_clamped = (filter_coeff > pve_pkg::COEF_ONE) ? pve_pkg::COEF_ONE
                                                            : filter_coeff;
  assign vel_diff = 33'(raw_velocity) - 33'(smoothed_velocity);
  assign prod_rnd = prod + 51'sd32768;
  assign filt_sum = 36'(smoothed_velocity) + 36'($signed(prod_rnd[50:16]));

  always_comb begin
    if (filt_sum > 36'sh0_7fff_ffff) begin
      filt_sat = pve_pkg::VEL_MAX;
    end else if (filt_sum < -36'sh0_8000_0000) begin
      filt_sat = pve_pkg::VEL_MIN;
    end else begin
      filt_sat = filt_sum[pve_pkg::VEL_W-1:0];
    end
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      max_ticks    <= pve_pkg::MAX_TICKS_RST;
      filter_coeff <= pve_pkg::FILTER_COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pve_pkg::REG_MAX_TICKS:    max_ticks    <= cfg_data[pve_pkg::TICK_W-1:0];
        pve_pkg::REG_FILTER_COEFF: filter_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      last_position     <= '0;
      elapsed_ticks     <= '0;
      raw_velocity      <= '0;
      smoothed_velocity <= '0;
      m_tvalid          <= 1'b0;
      div_cnt           <= '0;
    end else begin
      // writeback owns m_tvalid while it runs
      if (m_tvalid && m_tready && (state != ST_WB)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (pos_in != last_position) begin
              dvd      <= num_mag;
              quo_neg  <= diff[pve_pkg::POS_W-1];
              divisor  <= ticks_inc;
              rem      <= '0;
              div_cnt  <= '0;
              pos_hold <= pos_in;
              state    <= ST_DIV;
            end else begin
              // no change: count up, time out to zero velocity
              if (ticks_inc > {1'b0, max_ticks}) begin
                elapsed_ticks <= {1'b0, max_ticks};
                raw_velocity  <= '0;
              end else begin
                elapsed_ticks <= ticks_inc;
              end
              state <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          rem     <= rem_ge ? (rem_sh[pve_pkg::CNT_W-1:0] - divisor)
                            : rem_sh[pve_pkg::CNT_W-1:0];
          dvd     <= {dvd[pve_pkg::VEL_W-2:0], rem_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            // quotient magnitude is at most 2^31, so negation always fits
            raw_velocity  <= quo_neg ? (~{dvd[pve_pkg::VEL_W-2:0], rem_ge} + 32'd1)
                                     : {dvd[pve_pkg::VEL_W-2:0], rem_ge};
            last_position <= pos_hold;
            elapsed_ticks <= '0;
            state         <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= vel_diff * $signed({1'b0, coeff_clamped});
          state <= ST_FILT;
        end
        ST_FILT: begin
          smoothed_velocity <= filt_sat;
          state             <= ST_WB;
        end
        ST_WB: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {smoothed_velocity, raw_velocity};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/pve_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pve_checker: velocity predictor and scoreboard for the estimator
// Watches the request, result and config channels, predicts raw and filtered
// velocity for every accepted position request, and compares results in order.
// ----------------------------------------------------------------------------
module pve_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [pve_pkg::IN_W-1:0]      s_tdata,    // [15:0] position
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [pve_pkg::OUT_W-1:0]     m_tdata,    // [31:0] velocity, [63:32] filtered
  input  logic                          cfg_we,
  input  logic [pve_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pve_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            checked,
  output int                            timeouts
);

  typedef struct packed {
    logic signed [pve_pkg::VEL_W-1:0] vel;
    logic signed [pve_pkg::VEL_W-1:0] filt;
  } velocity_pair_t;

  velocity_pair_t          velocity_q[$];

  logic [pve_pkg::POS_W-1:0]        last_pos;
  logic [pve_pkg::CNT_W-1:0]        tick_cnt;
  logic signed [pve_pkg::VEL_W-1:0] raw_vel;
  logic signed [pve_pkg::VEL_W-1:0] smooth_vel;
  logic [pve_pkg::TICK_W-1:0]       max_ticks;
  logic [pve_pkg::COEF_W-1:0]       coeff;

  function automatic logic signed [pve_pkg::VEL_W-1:0] clamp_vel(input longint v);
    if (v > 64'sh0000_0000_7fff_ffff) return pve_pkg::VEL_MAX;
    if (v < 64'shffff_ffff_8000_0000) return pve_pkg::VEL_MIN;
    return v[pve_pkg::VEL_W-1:0];
  endfunction

  // one tick: elapsed-time velocity, timeout, then the Q16 low-pass
  task automatic estimate_velocity(input logic [pve_pkg::POS_W-1:0] pos);
    logic [pve_pkg::POS_W-1:0]        stride;
    logic signed [pve_pkg::POS_W-1:0] delta;
    longint                           quot;
    longint                           cw;
    longint                           acc;
    tick_cnt = tick_cnt + 1'b1;
    if (pos != last_pos) begin
      stride   = pos - last_pos;
      delta    = $signed(stride);
      quot     = (longint'(delta) * 65536) / longint'(tick_cnt);
      raw_vel  = clamp_vel(quot);
      last_pos = pos;
      tick_cnt = '0;
    end
    if (tick_cnt > {1'b0, max_ticks}) begin
      tick_cnt = {1'b0, max_ticks};
      raw_vel  = '0;
      timeouts++;
    end
    cw  = (coeff > pve_pkg::COEF_ONE) ? longint'(pve_pkg::COEF_ONE) : longint'(coeff);
    acc = longint'(raw_vel) * cw + longint'(smooth_vel) * (65536 - cw);
    smooth_vel = clamp_vel((acc + 32768) >>> pve_pkg::FRAC_W);
    velocity_q.push_back('{vel: raw_vel, filt: smooth_vel});
  endtask

  always @(posedge clk) begin
    velocity_pair_t want;
    if (rst) begin
      velocity_q.delete();
      last_pos   = '0;
      tick_cnt   = '0;
      raw_vel    = '0;
      smooth_vel = '0;
      max_ticks  = pve_pkg::MAX_TICKS_RST;
      coeff      = pve_pkg::FILTER_COEFF_RST;
      errors     = 0;
      checked    = 0;
      timeouts   = 0;
    end else begin
      // results first: a result can never belong to a request of the same edge
      if (m_tvalid && m_tready) begin
        if (velocity_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: velocity %0d filtered %0d", $time,
                   $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
        end else begin
          want = velocity_q.pop_front();
          checked++;
          if (m_tdata[31:0] !== want.vel) begin
            errors++;
            $display("%0t: velocity mismatch: expected %0d, got %0d", $time,
                     want.vel, $signed(m_tdata[31:0]));
          end
          if (m_tdata[63:32] !== want.filt) begin
            errors++;
            $display("%0t: filtered_velocity mismatch: expected %0d, got %0d", $time,
                     want.filt, $signed(m_tdata[63:32]));
          end
        end
      end
      if (s_tvalid && s_tready)
        estimate_velocity(s_tdata[pve_pkg::POS_W-1:0]);
      if (cfg_we) begin
        case (cfg_index)
          pve_pkg::REG_MAX_TICKS:    max_ticks = cfg_data[pve_pkg::TICK_W-1:0];
          pve_pkg::REG_FILTER_COEFF: coeff     = cfg_data[pve_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
    end
    pending = velocity_q.size();
  end

endmodule

// ----- tb/tb_period_velocity_estimator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_period_velocity_estimator_unit: stimulus and verdict for the estimator
// Drives position requests (directed wrap and extreme cases, then motion-like
// random sequences) across several timeout and filter settings and idle mixes,
// with one long output hold-off; pve_checker predicts and scores the results.
// ----------------------------------------------------------------------------
module tb_period_velocity_estimator_unit;

  localparam int N_PHASES     = 8;
  localparam int N_PER_PHASE  = 170;   // requests per register setting
  localparam int N_PRESSURE   = 60;
  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int DRAIN_CYCLES = 40;    // longer than the divide path

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [pve_pkg::IN_W-1:0]      s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [pve_pkg::OUT_W-1:0]     m_tdata;
  logic                          cfg_we = 1'b0;
  logic [pve_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pve_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int checked;
  int timeouts;

  int send_idle_pct = 0;   // sender side, read only by the stimulus process
  int stall_pct = 0;       // receiver side, written by NBA
  bit long_hold = 1'b0;
  int hold_cnt = 0;
  int n_sent = 0;
  logic [pve_pkg::POS_W-1:0] cur_pos = '0;

  // timeout / weight per phase; entry 6 is randomized at start
  int unsigned max_tab   [N_PHASES] = '{0, 1, 65535, 7, 30, 2000, 0, 3};
  int unsigned coeff_tab [N_PHASES] = '{65536, 0, 131071, 40000, 65537, 1993, 0, 1};

  // wrap points, sign extremes and alternating bit patterns
  logic [pve_pkg::POS_W-1:0] directed [20] = '{
    16'h0000, 16'h0000, 16'h0064, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000,
    16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h5555, 16'haaaa, 16'h5555,
    16'h0001, 16'h0001, 16'hfffe, 16'h0000
  };

  period_velocity_estimator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pve_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .timeouts  (timeouts)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off counted here once
  // long_hold goes up. The result register fills, writeback blocks and the
  // block drops s_tready while the sender keeps offering.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold && hold_cnt < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      if (!long_hold) hold_cnt <= 0;
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One position request. Entered and left at a falling edge; s_tvalid
  // stays high across back-to-back requests.
  task automatic send_pos(input logic [pve_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // all results back, then let the block settle before touching registers
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pve_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[pve_pkg::CFG_DAT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Motion-like stream: a move then a dwell at the same position. Moves are
  // mostly small strides, some random strides over the full position range,
  // some +/-1. Dwells run past the timeout now and then when it is short.
  task automatic run_motion(input int n_items, input int unsigned tmo);
    int stride;
    int dwell;
    int sent_here;
    int pick;
    sent_here = 0;
    while (sent_here < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60)      stride = int'($urandom_range(64)) - 32;
      else if (pick < 85) stride = int'($urandom_range(65535));
      else                stride = $urandom_range(1) ? 1 : -1;
      cur_pos = cur_pos + stride[pve_pkg::POS_W-1:0];
      send_pos(cur_pos);
      sent_here++;
      if (tmo < 40 && $urandom_range(3) == 0) dwell = int'(tmo) + int'($urandom_range(2));
      else                                    dwell = $urandom_range(5);
      for (int i = 0; i < dwell && sent_here < n_items; i++) begin
        send_pos(cur_pos);
        sent_here++;
      end
    end
  endtask

  initial begin
    int unsigned cur_tmo;
    max_tab[6]   = $urandom_range(50, 1);
    coeff_tab[6] = $urandom_range(131071);
    cur_tmo      = pve_pkg::MAX_TICKS_RST;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed requests under the reset settings
    foreach (directed[i]) send_pos(directed[i]);
    cur_pos = directed[19];
    drain_results;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 49; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 49; end
        default: begin send_idle_pct = 34; stall_pct <= 34; end
      endcase
      write_reg(pve_pkg::REG_MAX_TICKS, max_tab[ph]);
      write_reg(pve_pkg::REG_FILTER_COEFF, coeff_tab[ph]);
      cur_tmo = max_tab[ph] & 32'hffff;
      run_motion(N_PER_PHASE, cur_tmo);
      drain_results;
    end

    // back-pressure: output held off while requests keep coming
    send_idle_pct = 0;
    stall_pct <= 0;
    long_hold <= 1'b1;
    run_motion(N_PRESSURE, cur_tmo);
    drain_results;
    long_hold <= 1'b0;

    $display("summary: %0d position requests under %0d register settings and four idle mixes",
             n_sent, N_PHASES + 1);
    $display("summary: %0d results checked, %0d timeout ticks, one %0d-cycle output hold-off",
             checked, timeouts, HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pve_pkg.sv
hdl/period_velocity_estimator_unit.sv
tb/pve_checker.sv
tb/tb_period_velocity_estimator_unit.sv
